// ===== src/urxf_pkg.sv =====
`timescale 1ns / 1ps

package urxf_pkg;

  // Receive FIFO depth; the ring holds FIFO_DEPTH-1 bytes.
  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  localparam int BIT_TIME_W = 20;
  localparam int RX_TIMER_W = BIT_TIME_W + 1;

  localparam int DATA_BITS  = 8;
  localparam int FRAME_BITS = 10;
  localparam int FRAME_W    = FRAME_BITS;
  localparam int COUNT_W    = 4;

  localparam logic [FRAME_W-1:0] FRAME_STOP_MARK = 10'h200;
  localparam logic [FRAME_W-1:0] FRAME_IDLE      = 10'h3FF;

  localparam logic [BIT_TIME_W-1:0] DATA_BIT_TICKS_RESET    = 20'd8333;
  localparam logic [BIT_TIME_W-1:0] COMMAND_BIT_TICKS_RESET = 20'd2083;

  localparam int CFG_ADDR_W = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DATA_BIT_TICKS    = 2'd0,
    CFG_COMMAND_BIT_TICKS = 2'd1,
    CFG_COMMAND_MODE      = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic       rx_level;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       take_request;
  } in_item_t;

  typedef struct packed {
    logic       tx_level;
    logic       tx_busy;
    logic       take_valid;
    logic [7:0] take_byte;
    logic       enable_level;
  } out_item_t;

endpackage

// ===== src/uart_8n1_transceiver_rx_fifo.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_ready     urxf_pkg::in_item_t (one clock tick)
// out_      output     out_valid / out_ready   urxf_pkg::out_item_t (one per item)
// cfg_      input      cfg_we                  cfg_addr, cfg_data (20 bits)
//
// Every item is one tick of the bit timers and yields exactly one result item.
// An item is accepted in every cycle in which the output register is empty or
// is being emptied, so the sustained rate is one item per cycle while out_ready is high.
// The receive FIFO is a synchronous RAM; a pop reads it at acceptance and the
// byte lands in the result in the cycle after, together with the rest of the item.
// Reset is synchronous and active low; the FIFO contents are not cleared.
// A stalled output holds its result, and new items wait until it is taken.

module uart_8n1_transceiver_rx_fifo (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  urxf_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output urxf_pkg::out_item_t                    out_data,
  input  logic                                   cfg_we,
  input  logic [urxf_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [urxf_pkg::BIT_TIME_W-1:0]        cfg_data
);

  localparam int PTR_W  = urxf_pkg::PTR_W;
  localparam int BT_W   = urxf_pkg::BIT_TIME_W;
  localparam int RXT_W  = urxf_pkg::RX_TIMER_W;
  localparam int CNT_W  = urxf_pkg::COUNT_W;
  localparam int FRM_W  = urxf_pkg::FRAME_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(urxf_pkg::FIFO_DEPTH - 1);

  // Configuration registers.
  logic [BT_W-1:0] data_bt_r;
  logic [BT_W-1:0] cmd_bt_r;
  logic            cmd_mode_r;

  // Receiver state.
  logic             rx_active_r, rx_active_nxt;
  logic [RXT_W-1:0] rx_timer_r, rx_timer_nxt;
  logic [CNT_W-1:0] rx_count_r, rx_count_nxt;
  logic [7:0]       rx_shift_r, rx_shift_nxt;

  // FIFO pointers and RAM.
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [7:0]       fifo_mem [urxf_pkg::FIFO_DEPTH];
  logic [7:0]       mem_q_r;

  // Transmitter state.
  logic [FRM_W-1:0] tx_shift_r, tx_shift_nxt;
  logic [CNT_W-1:0] tx_left_r, tx_left_nxt;
  logic [BT_W-1:0]  tx_timer_r, tx_timer_nxt;

  // Output register.
  logic out_valid_r;
  logic out_tx_level_r, out_tx_busy_r, out_take_valid_r, out_enable_r;

  logic             accept;
  logic [BT_W-1:0]  bit_time;
  logic             do_pop;
  logic             do_push;
  logic [PTR_W-1:0] head_inc;
  logic [RXT_W-1:0] rx_tdec;
  logic [BT_W-1:0]  tx_tdec;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign bit_time = cmd_mode_r ? cmd_bt_r : data_bt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_bt_r  <= urxf_pkg::DATA_BIT_TICKS_RESET;
      cmd_bt_r   <= urxf_pkg::COMMAND_BIT_TICKS_RESET;
      cmd_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        urxf_pkg::CFG_DATA_BIT_TICKS:    data_bt_r  <= cfg_data;
        urxf_pkg::CFG_COMMAND_BIT_TICKS: cmd_bt_r   <= cfg_data;
        urxf_pkg::CFG_COMMAND_MODE:      cmd_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pop comes first in a tick, so a push in the same tick sees the freed slot.
  always_comb begin
    do_pop   = in_data.take_request && (head_r != tail_r);
    tail_nxt = tail_r;
    if (do_pop) begin
      tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
    end
  end

  assign head_inc = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;

  // Receiver: waits for a start level, samples mid-bit, ends one bit time later.
  always_comb begin
    rx_active_nxt = rx_active_r;
    rx_timer_nxt  = rx_timer_r;
    rx_count_nxt  = rx_count_r;
    rx_shift_nxt  = rx_shift_r;
    do_push       = 1'b0;
    rx_tdec       = (rx_timer_r != '0) ? rx_timer_r - 1'b1 : rx_timer_r;
    if (!rx_active_r) begin
      if (!in_data.rx_level) begin
        rx_active_nxt = 1'b1;
        rx_timer_nxt  = {1'b0, bit_time} + {2'b00, bit_time[BT_W-1:1]};
        rx_count_nxt  = '0;
        rx_shift_nxt  = '0;
      end
    end else begin
      rx_timer_nxt = rx_tdec;
      if (rx_tdec == '0) begin
        if (rx_count_r < CNT_W'(urxf_pkg::DATA_BITS)) begin
          rx_shift_nxt[rx_count_r[2:0]] = rx_shift_r[rx_count_r[2:0]] | in_data.rx_level;
          rx_count_nxt = rx_count_r + 1'b1;
          rx_timer_nxt = {1'b0, bit_time};
        end else begin
          // A full FIFO drops the byte.
          do_push       = (head_inc != tail_nxt);
          rx_active_nxt = 1'b0;
          rx_count_nxt  = '0;
        end
      end
    end
    head_nxt = do_push ? head_inc : head_r;
  end

  // Transmitter: start, eight data bits, stop; a new frame may start on the
  // tick that ends the stop bit.
  always_comb begin
    tx_shift_nxt = tx_shift_r;
    tx_left_nxt  = tx_left_r;
    tx_timer_nxt = tx_timer_r;
    tx_tdec      = (tx_timer_r != '0) ? tx_timer_r - 1'b1 : tx_timer_r;
    if (tx_left_r != '0) begin
      tx_timer_nxt = tx_tdec;
      if (tx_tdec == '0) begin
        tx_shift_nxt = {1'b1, tx_shift_r[FRM_W-1:1]};
        tx_left_nxt  = tx_left_r - 1'b1;
        tx_timer_nxt = bit_time;
        if (tx_left_nxt == '0) begin
          tx_shift_nxt = urxf_pkg::FRAME_IDLE;
          tx_timer_nxt = '0;
        end
      end
    end
    if ((tx_left_nxt == '0) && in_data.send_valid) begin
      tx_shift_nxt = urxf_pkg::FRAME_STOP_MARK | {1'b0, in_data.send_byte, 1'b0};
      tx_left_nxt  = CNT_W'(urxf_pkg::FRAME_BITS);
      tx_timer_nxt = bit_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_active_r <= 1'b0;
      rx_timer_r  <= '0;
      rx_count_r  <= '0;
      rx_shift_r  <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      tx_shift_r  <= urxf_pkg::FRAME_IDLE;
      tx_left_r   <= '0;
      tx_timer_r  <= '0;
    end else if (accept) begin
      rx_active_r <= rx_active_nxt;
      rx_timer_r  <= rx_timer_nxt;
      rx_count_r  <= rx_count_nxt;
      rx_shift_r  <= rx_shift_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      tx_shift_r  <= tx_shift_nxt;
      tx_left_r   <= tx_left_nxt;
      tx_timer_r  <= tx_timer_nxt;
    end
  end

  // A popped entry was always written on an earlier item, and a push never
  // targets the entry being popped, so no bypass around the RAM is needed.
  always_ff @(posedge clk) begin
    if (accept && do_push) begin
      fifo_mem[head_r] <= rx_shift_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && do_pop) begin
      mem_q_r <= fifo_mem[tail_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_tx_level_r   <= tx_shift_nxt[0];
      out_tx_busy_r    <= (tx_left_nxt != '0);
      out_take_valid_r <= do_pop;
      out_enable_r     <= cmd_mode_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_data.tx_level      = out_tx_level_r;
  assign out_data.tx_busy       = out_tx_busy_r;
  assign out_data.take_valid    = out_take_valid_r;
  assign out_data.take_byte     = out_take_valid_r ? mem_q_r : 8'h00;
  assign out_data.enable_level  = out_enable_r;

`ifndef NO_ASSERTIONS
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    accept && do_push |=> head_r != tail_r)
    else $error("push left the FIFO looking empty");

  a_pop_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept && do_pop |=> out_valid && out_data.take_valid)
    else $error("popped byte missing from result");

  a_idle_line_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.tx_busy |-> out_data.tx_level)
    else $error("transmit line low while idle");

  a_tx_idle_frame: assert property (@(posedge clk) disable iff (!rst_n)
    tx_left_r == '0 |-> tx_shift_r == urxf_pkg::FRAME_IDLE)
    else $error("idle transmitter holds a partial frame");

  a_rx_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    rx_count_r <= CNT_W'(urxf_pkg::DATA_BITS))
    else $error("receive bit count out of range");
`endif

endmodule
